### src/ypvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_pkg
// Shared types, constants and the cordic arctangent table for the
// yaw/pitch view matrix pipeline.
// ----------------------------------------------------------------------------
package ypvm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STEPS      = 30;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // input beat
    typedef struct packed {
        logic        [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [31:0] trans_right;
        logic signed [31:0] trans_up;
        logic signed [31:0] trans_fwd;
    } t_out_beat;

    // atan(2^-i) in turns scaled by 2^32
    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] r;
        r = 34'sd0;
        case (i)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### src/yaw_pitch_view_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix
// Camera view matrix axes and translations from yaw, pitch and eye position.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid / o_stall) carries one beat holding
// yaw, pitch and the eye position; the output channel (o_valid / i_stall)
// carries one beat with right, up and forward axes in Q1.F and the three
// translations in Q16.16, saturated. One output beat per input beat.
// Throughput is one beat per cycle while the receiver does not stall.
// The pipe has one fold stage, 30 cordic micro-rotation stages, then multiply,
// cross product, rounding, dot-product multiply and sum/saturate stages. The
// whole pipeline is a single enable chain: when the receiver stalls with a
// beat waiting at the output, every stage holds and o_stall is raised, so
// nothing is lost or repeated. Bubbles are not removed: the pipe advances
// whenever the last stage is empty or taken. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module yaw_pitch_view_matrix #(
    parameter int ANGLE_BITS    = ypvm_pkg::ANGLE_BITS_DEF,
    parameter int DIR_FRAC_BITS = ypvm_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire ypvm_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output ypvm_pkg::t_out_beat  o_data
);
    localparam int N    = ypvm_pkg::CORDIC_STEPS;
    localparam int LAT  = N + 6;
    localparam int SH   = 32 - ANGLE_BITS;
    localparam int DSH  = 30 - DIR_FRAC_BITS;
    localparam logic signed [33:0] QUARTER = 34'sd1 <<< (ANGLE_BITS - 2);
    localparam logic signed [33:0] ONE     = 34'sd1 <<< DIR_FRAC_BITS;

    logic en;
    logic [LAT-1:0] r_vld;

    // the pipe moves unless a finished beat is held by the receiver
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // angle formatting
    logic signed [33:0] pitch_c;
    logic        [31:0] yaw_turn, pitch_turn;
    always_comb begin
        pitch_c = 34'(i_data.pitch_angle);
        if (pitch_c > QUARTER)  pitch_c = QUARTER;
        if (pitch_c < -QUARTER) pitch_c = -QUARTER;
        yaw_turn   = 32'({16'd0, i_data.yaw_angle} << SH);
        pitch_turn = 32'(pitch_c <<< SH);
    end

    logic signed [33:0] sy, cy, sp, cp;
    ypvm_cordic u_yaw (.i_clk, .i_en(en), .i_turn(yaw_turn), .o_sin(sy), .o_cos(cy));
    ypvm_cordic u_pit (.i_clk, .i_en(en), .i_turn(pitch_turn), .o_sin(sp), .o_cos(cp));

    // eye delay line matching the cordic, forward, cross-product and rounding stages
    logic signed [31:0] r_ex [0:LAT-3];
    logic signed [31:0] r_ey [0:LAT-3];
    logic signed [31:0] r_ez [0:LAT-3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex[0] <= i_data.eye_x;
            r_ey[0] <= i_data.eye_y;
            r_ez[0] <= i_data.eye_z;
            for (int k = 1; k < LAT-2; k++) begin
                r_ex[k] <= r_ex[k-1];
                r_ey[k] <= r_ey[k-1];
                r_ez[k] <= r_ez[k-1];
            end
        end
    end

    function automatic logic signed [33:0] mulq30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
        return 34'(p >>> 30);
    endfunction

    function automatic logic signed [33:0] to_dir(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + (34'sd1 <<< DSH) / 2) >>> DSH;
        if (r > ONE)  r = ONE;
        if (r < -ONE) r = -ONE;
        return r;
    endfunction

    // stage: forward from the two rotations
    logic signed [33:0] r_fx, r_fy, r_fz, r_rx, r_rz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx <= mulq30(sy, cp);
            r_fy <= sp;
            r_fz <= mulq30(cy, cp);
            r_rx <= cy;
            r_rz <= -sy;
        end
    end

    // stage: up cross-product terms
    logic signed [33:0] r_ux, r_uy_a, r_uy_b, r_uz;
    logic signed [33:0] r_fx2, r_fy2, r_fz2, r_rx2, r_rz2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux   <= mulq30(r_fy, r_rz);
            r_uy_a <= mulq30(r_fz, r_rx);
            r_uy_b <= mulq30(r_fx, r_rz);
            r_uz   <= -mulq30(r_fy, r_rx);
            r_fx2 <= r_fx; r_fy2 <= r_fy; r_fz2 <= r_fz;
            r_rx2 <= r_rx; r_rz2 <= r_rz;
        end
    end

    // stage: round all axes to output format
    logic signed [33:0] r_d [0:7];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0] <= to_dir(r_rx2);
            r_d[1] <= to_dir(r_rz2);
            r_d[2] <= to_dir(r_ux);
            r_d[3] <= to_dir(r_uy_a - r_uy_b);
            r_d[4] <= to_dir(r_uz);
            r_d[5] <= to_dir(r_fx2);
            r_d[6] <= to_dir(r_fy2);
            r_d[7] <= to_dir(r_fz2);
        end
    end

    // stage: dot-product products
    logic signed [65:0] r_p [0:7];
    logic signed [33:0] r_d2 [0:7];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= 66'(r_d[0]) * 66'(r_ex[LAT-3]);
            r_p[1] <= 66'(r_d[1]) * 66'(r_ez[LAT-3]);
            r_p[2] <= 66'(r_d[2]) * 66'(r_ex[LAT-3]);
            r_p[3] <= 66'(r_d[3]) * 66'(r_ey[LAT-3]);
            r_p[4] <= 66'(r_d[4]) * 66'(r_ez[LAT-3]);
            r_p[5] <= 66'(r_d[5]) * 66'(r_ex[LAT-3]);
            r_p[6] <= 66'(r_d[6]) * 66'(r_ey[LAT-3]);
            r_p[7] <= 66'(r_d[7]) * 66'(r_ez[LAT-3]);
            for (int k = 0; k < 8; k++) r_d2[k] <= r_d[k];
        end
    end

    function automatic logic signed [31:0] sat_tr(input logic signed [67:0] s);
        logic signed [67:0] t;
        t = ((-s) + (68'sd1 <<< DIR_FRAC_BITS) / 2) >>> DIR_FRAC_BITS;
        if (t > 68'sd2147483647)  t = 68'sd2147483647;
        if (t < -68'sd2147483648) t = -68'sd2147483648;
        return 32'(t);
    endfunction

    // stage: sums, rounding and saturation into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.right_x <= 16'(r_d2[0]);
            o_data.right_z <= 16'(r_d2[1]);
            o_data.up_x    <= 16'(r_d2[2]);
            o_data.up_y    <= 16'(r_d2[3]);
            o_data.up_z    <= 16'(r_d2[4]);
            o_data.fwd_x   <= 16'(r_d2[5]);
            o_data.fwd_y   <= 16'(r_d2[6]);
            o_data.fwd_z   <= 16'(r_d2[7]);
            o_data.trans_right <= sat_tr(68'(r_p[0]) + 68'(r_p[1]));
            o_data.trans_up    <= sat_tr(68'(r_p[2]) + 68'(r_p[3]) + 68'(r_p[4]));
            o_data.trans_fwd   <= sat_tr(68'(r_p[5]) + 68'(r_p[6]) + 68'(r_p[7]));
        end
    end

    // checks
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output hold");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall && !o_stall |=> r_vld[0] == $past(i_valid))
        else $error("accepted beat not entered in pipe");
endmodule
`default_nettype wire

### src/ypvm_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ypvm_cordic
// Pipelined rotation-mode cordic, one micro-rotation per stage, giving
// Q30 sine and cosine of a 32-bit turn fraction. Advances when i_en.
// ----------------------------------------------------------------------------
module ypvm_cordic (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire        [31:0] i_turn,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);
    localparam int N = ypvm_pkg::CORDIC_STEPS;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [33:0] r_z [0:N];
    logic               r_flip [0:N];

    // quadrant fold into the right half plane
    logic        n_flip;
    logic [31:0] n_turn;
    assign n_flip = i_turn[31] ^ i_turn[30];
    assign n_turn = n_flip ? (i_turn ^ 32'h8000_0000) : i_turn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= ypvm_pkg::CORDIC_GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= 34'(signed'(n_turn));
            r_flip[0] <= n_flip;
        end
    end

    // micro-rotation stages
    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ypvm_pkg::atan_turn(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ypvm_pkg::atan_turn(g);
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    assign o_sin = r_flip[N] ? -r_y[N] : r_y[N];
    assign o_cos = r_flip[N] ? -r_x[N] : r_x[N];
endmodule
`default_nettype wire

### sim/yaw_pitch_view_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix_tb
// Drives yaw, pitch and eye position beats into the view matrix pipeline.
// Every output beat is checked field by field against a cordic-based
// prediction of the camera axes and translations. The test covers directed
// corner angles, pitch clamping and translation saturation, then random
// views with bursts of input and output stalls, a long output hold-off and
// a pause until the pipeline is empty.
// ----------------------------------------------------------------------------
module yaw_pitch_view_matrix_tb;

    localparam int  CLK_HALF     = 5;
    localparam int  PIPE_DEPTH   = 36;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  NUM_RANDOM   = 600;
    localparam longint DIR_ONE   = 64'sd16384;

    // atan(2^-i) as turn fraction scaled by 2^32
    localparam longint ATAN_TURN32 [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    ypvm_pkg::t_in_beat   i_data;
    logic       o_valid;
    logic       i_stall;
    ypvm_pkg::t_out_beat  o_data;

    ypvm_pkg::t_out_beat  expected_views[$];
    int         error_count;
    int         cycle_count;
    bit         idle_en;
    int         out_hold_cycles;
    int         out_stall_left;

    yaw_pitch_view_matrix u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // add one half, then arithmetic shift
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // sine and cosine in q30 for a 32-bit turn fraction
    function automatic void cordic_sincos(input logic [31:0] turn,
                                          output longint s, output longint c);
        logic [31:0] shifted;
        logic        flip;
        longint      x, y, z, dx, dy;
        shifted = turn + 32'h4000_0000;
        flip    = shifted[31];
        if (flip)
            turn[31] = ~turn[31];
        x = 64'sd652032874;
        y = 0;
        z = longint'($signed(turn));
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN32[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN32[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return round_half_up(a * b, 30);
    endfunction

    // q30 to q1.14 with clamp to +-1
    function automatic longint q30_to_dir(input longint v);
        longint r;
        r = round_half_up(v, 16);
        if (r > DIR_ONE)
            r = DIR_ONE;
        if (r < -DIR_ONE)
            r = -DIR_ONE;
        return r;
    endfunction

    // negated axis dot eye, q16.16, saturated
    function automatic longint axis_translation(input longint ax, input longint ay,
                                                input longint az,
                                                input ypvm_pkg::t_in_beat b);
        longint t;
        t = -(ax * longint'(b.eye_x) + ay * longint'(b.eye_y) + az * longint'(b.eye_z));
        t = round_half_up(t, 14);
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t;
    endfunction

    function automatic ypvm_pkg::t_out_beat predict_view(input ypvm_pkg::t_in_beat b);
        ypvm_pkg::t_out_beat r;
        longint      pitch, sy, cy, sp, cp;
        longint      fx, fy, fz, rx, rz, ux, uy, uz;
        longint      d [8];
        logic [31:0] yaw_turn, pitch_turn;
        pitch = longint'(b.pitch_angle);
        if (pitch > 16384)
            pitch = 16384;
        if (pitch < -16384)
            pitch = -16384;
        yaw_turn   = {b.yaw_angle, 16'h0000};
        pitch_turn = {pitch[15:0], 16'h0000};
        cordic_sincos(yaw_turn, sy, cy);
        cordic_sincos(pitch_turn, sp, cp);
        fx = q30_mul(sy, cp);
        fy = sp;
        fz = q30_mul(cy, cp);
        rx = cy;
        rz = -sy;
        ux = q30_mul(fy, rz);
        uy = q30_mul(fz, rx) - q30_mul(fx, rz);
        uz = -q30_mul(fy, rx);
        d[0] = q30_to_dir(rx); d[1] = q30_to_dir(rz);
        d[2] = q30_to_dir(ux); d[3] = q30_to_dir(uy); d[4] = q30_to_dir(uz);
        d[5] = q30_to_dir(fx); d[6] = q30_to_dir(fy); d[7] = q30_to_dir(fz);
        r.right_x     = d[0][15:0];
        r.right_z     = d[1][15:0];
        r.up_x        = d[2][15:0];
        r.up_y        = d[3][15:0];
        r.up_z        = d[4][15:0];
        r.fwd_x       = d[5][15:0];
        r.fwd_y       = d[6][15:0];
        r.fwd_z       = d[7][15:0];
        r.trans_right = 32'(axis_translation(d[0], 0, d[1], b));
        r.trans_up    = 32'(axis_translation(d[2], d[3], d[4], b));
        r.trans_fwd   = 32'(axis_translation(d[5], d[6], d[7], b));
        return r;
    endfunction

    task automatic compare_field(input string name, input longint exp_v,
                                 input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic check_view(input ypvm_pkg::t_out_beat act);
        ypvm_pkg::t_out_beat exp_v;
        if (expected_views.size() == 0) begin
            $display("%0t: unexpected output beat, expected none, actual %h", $time, act);
            error_count++;
            return;
        end
        exp_v = expected_views.pop_front();
        compare_field("right_x", exp_v.right_x, act.right_x);
        compare_field("right_z", exp_v.right_z, act.right_z);
        compare_field("up_x", exp_v.up_x, act.up_x);
        compare_field("up_y", exp_v.up_y, act.up_y);
        compare_field("up_z", exp_v.up_z, act.up_z);
        compare_field("fwd_x", exp_v.fwd_x, act.fwd_x);
        compare_field("fwd_y", exp_v.fwd_y, act.fwd_y);
        compare_field("fwd_z", exp_v.fwd_z, act.fwd_z);
        compare_field("trans_right", exp_v.trans_right, act.trans_right);
        compare_field("trans_up", exp_v.trans_up, act.trans_up);
        compare_field("trans_fwd", exp_v.trans_fwd, act.trans_fwd);
    endtask

    // output side: check accepted beats, drive stall bursts and hold-offs
    initial begin
        i_stall        = 1'b0;
        out_stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                check_view(o_data);
            if (out_hold_cycles > 0) begin
                out_hold_cycles--;
                i_stall <= 1'b1;
            end else if (out_stall_left > 0) begin
                out_stall_left--;
                i_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                out_stall_left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // send one beat, record its prediction on acceptance
    task automatic send_view(input ypvm_pkg::t_in_beat b);
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_views.push_back(predict_view(b));
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_angles(input logic [15:0] yaw, input logic [15:0] pitch,
                               input logic [31:0] ex, input logic [31:0] ey,
                               input logic [31:0] ez);
        ypvm_pkg::t_in_beat b;
        b.yaw_angle   = yaw;
        b.pitch_angle = pitch;
        b.eye_x       = ex;
        b.eye_y       = ey;
        b.eye_z       = ez;
        send_view(b);
    endtask

    function automatic logic [31:0] random_eye();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    // quadrant boundaries of yaw and the pitch poles
    task automatic test_axis_extremes();
        send_angles(16'h0000, 16'sd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_angles(16'h4000, 16'sd0, 32'h0001_0000, 32'h0, 32'h0);
        send_angles(16'h8000, 16'sd16384, 32'h0, 32'h0001_0000, 32'h0);
        send_angles(16'hc000, -16'sd16384, 32'h0, 32'h0, 32'h0001_0000);
        send_angles(16'hffff, 16'sd1, 32'h1, 32'hffff_ffff, 32'h1);
        send_angles(16'h2000, 16'sd8192, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_angles(16'h6000, -16'sd8192, 32'hffff_8000, 32'h0, 32'h0000_2000);
        send_angles(16'h0001, 16'sd16383, 32'h0, 32'h0, 32'h0);
    endtask

    // pitch outside a quarter turn is clamped
    task automatic test_pitch_clamp();
        send_angles(16'h1234, 16'sh7fff, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_angles(16'h1234, 16'sh8000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_angles(16'h9abc, 16'sd16385, 32'h0, 32'h0001_0000, 32'h0);
        send_angles(16'h9abc, -16'sd16385, 32'h0, 32'h0001_0000, 32'h0);
        send_angles(16'h5555, 16'sd20000, 32'h0, 32'h0, 32'h0);
    endtask

    // eye extremes drive translations into saturation
    task automatic test_translation_saturation();
        send_angles(16'h2000, 16'sd4096, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_angles(16'h2000, 16'sd4096, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_angles(16'ha000, -16'sd4096, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_angles(16'h0000, 16'sd0, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
        send_angles(16'h8000, 16'sd0, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
        send_angles(16'he000, 16'sd12000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0001);
    endtask

    task automatic test_random_views(input int count, input bit with_idle);
        ypvm_pkg::t_in_beat b;
        idle_en = with_idle;
        for (int n = 0; n < count; n++) begin
            b.yaw_angle = $urandom();
            if ($urandom_range(0, 7) == 0)
                b.pitch_angle = $urandom();
            else
                b.pitch_angle = 16'($signed($urandom_range(0, 32768)) - 16384);
            b.eye_x = random_eye();
            b.eye_y = random_eye();
            b.eye_z = random_eye();
            send_view(b);
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_holdoff();
        idle_en = 1'b0;
        out_hold_cycles = 150;
        test_random_views(80, 1'b0);
    endtask

    // sender pauses until the pipeline has drained
    task automatic test_drain_pause();
        test_random_views(20, 1'b1);
        wait_drained();
        test_random_views(20, 1'b1);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data          = '0;
        idle_en         = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        out_hold_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_en = 1'b1;
        test_axis_extremes();
        test_pitch_clamp();
        test_translation_saturation();
        test_random_views(NUM_RANDOM / 2, 1'b1);
        test_output_holdoff();
        test_drain_pause();
        test_random_views(NUM_RANDOM / 4, 1'b1);
        test_random_views(NUM_RANDOM / 8, 1'b0);
        wait_drained();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
